FILE: src/flt_pkg.sv
// Shared types and constants for the fraction reduction block.
`default_nettype none
package flt_pkg;

    localparam int WIDTH_DEFAULT = 32;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_DEN_ZERO = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic gcd_step;
        logic gcd_finish;
        logic div_step;
        logic out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic den_zero;
        logic gcd_done;
    } t_ctrl_sts;

endpackage
`default_nettype wire

FILE: src/flt_if.sv
// Handshake channels for fraction items and reduced results.
`default_nettype none
interface flt_in_if #(
    parameter int WIDTH = flt_pkg::WIDTH_DEFAULT
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] num_in;
    logic [WIDTH-1:0] den_in;

    modport source (output valid, output num_in, output den_in, input ready);
    modport sink   (input valid, input num_in, input den_in, output ready);
endinterface

interface flt_out_if #(
    parameter int WIDTH = flt_pkg::WIDTH_DEFAULT
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] num_out;
    logic [WIDTH-1:0] den_out;
    logic [WIDTH-2:0] common_divisor;
    logic             status;

    modport source (output valid, output num_out, output den_out,
                    output common_divisor, output status, input ready);
    modport sink   (input valid, input num_out, input den_out,
                    input common_divisor, input status, output ready);
endinterface
`default_nettype wire

FILE: src/flt_ctrl.sv
// Sequencing state machine for load, gcd, division and result handoff.
`default_nettype none
module flt_ctrl #(
    parameter int WIDTH = flt_pkg::WIDTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  flt_pkg::t_ctrl_sts  i_sts,
    output flt_pkg::t_ctrl_cmd  o_cmd
);
    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    flt_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= flt_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            flt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = flt_pkg::ST_GCD;
                end
            end
            flt_pkg::ST_GCD: begin
                if (i_sts.den_zero) begin
                    n_state = flt_pkg::ST_DONE;
                end else if (i_sts.gcd_done) begin
                    o_cmd.gcd_finish = 1'b1;
                    n_cnt            = '0;
                    n_state          = flt_pkg::ST_DIV;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            flt_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CW'(WIDTH - 1)) begin
                    n_state = flt_pkg::ST_DONE;
                end
            end
            flt_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = flt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = flt_pkg::ST_IDLE;
            end
        endcase
        n_out_valid = o_cmd.out_load | (r_out_valid & ~i_out_ready);
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

FILE: src/flt_datapath.sv
// Operand registers, binary gcd unit, two restoring dividers, result register.
`default_nettype none
module flt_datapath #(
    parameter int WIDTH = flt_pkg::WIDTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic [WIDTH-1:0]   i_num_in,
    input  logic [WIDTH-1:0]   i_den_in,
    input  flt_pkg::t_ctrl_cmd i_cmd,
    output flt_pkg::t_ctrl_sts o_sts,
    output logic [WIDTH-1:0]   o_num_out,
    output logic [WIDTH-1:0]   o_den_out,
    output logic [WIDTH-2:0]   o_common_divisor,
    output logic               o_status
);
    localparam int KW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic [WIDTH-1:0] r_n_raw, r_d_raw;
    logic [WIDTH-1:0] r_a, r_b, r_g;
    logic [KW-1:0]    r_k;
    logic [WIDTH-1:0] r_qn, r_qd, r_rn, r_rd;
    logic [WIDTH-1:0] r_num_out, r_den_out;
    logic [WIDTH-2:0] r_cd;
    logic             r_status;

    logic [WIDTH-1:0] in_num_mag, in_den_mag, n_mag, d_mag;
    logic [WIDTH-1:0] rn_sh, rd_sh, num_q_signed, den_q_signed;
    logic             n_neg, d_neg, num_zero;

    assign in_num_mag = i_num_in[WIDTH-1] ? (~i_num_in + 1'b1) : i_num_in;
    assign in_den_mag = i_den_in[WIDTH-1] ? (~i_den_in + 1'b1) : i_den_in;
    assign n_neg      = r_n_raw[WIDTH-1];
    assign d_neg      = r_d_raw[WIDTH-1];
    assign n_mag      = n_neg ? (~r_n_raw + 1'b1) : r_n_raw;
    assign d_mag      = d_neg ? (~r_d_raw + 1'b1) : r_d_raw;
    assign num_zero   = (r_n_raw == '0);

    assign rn_sh = {r_rn[WIDTH-2:0], r_qn[WIDTH-1]};
    assign rd_sh = {r_rd[WIDTH-2:0], r_qd[WIDTH-1]};

    assign num_q_signed = n_neg ? (~r_qn + 1'b1) : r_qn;
    assign den_q_signed = d_neg ? (~r_qd + 1'b1) : r_qd;

    assign o_sts.den_zero = (r_d_raw == '0);
    assign o_sts.gcd_done = (r_a == '0) || (r_b == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n_raw <= i_num_in;
            r_d_raw <= i_den_in;
            r_a     <= in_num_mag;
            r_b     <= in_den_mag;
            r_k     <= '0;
        end else if (i_cmd.gcd_step) begin
            if (!r_a[0] && !r_b[0]) begin
                r_a <= r_a >> 1;
                r_b <= r_b >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_a[0]) begin
                r_a <= r_a >> 1;
            end else if (!r_b[0]) begin
                r_b <= r_b >> 1;
            end else if (r_a >= r_b) begin
                r_a <= r_a - r_b;
            end else begin
                r_b <= r_b - r_a;
            end
        end

        if (i_cmd.gcd_finish) begin
            r_g  <= (r_a | r_b) << r_k;
            r_qn <= n_mag;
            r_qd <= d_mag;
            r_rn <= '0;
            r_rd <= '0;
        end else if (i_cmd.div_step) begin
            if (rn_sh >= r_g) begin
                r_rn <= rn_sh - r_g;
                r_qn <= {r_qn[WIDTH-2:0], 1'b1};
            end else begin
                r_rn <= rn_sh;
                r_qn <= {r_qn[WIDTH-2:0], 1'b0};
            end
            if (rd_sh >= r_g) begin
                r_rd <= rd_sh - r_g;
                r_qd <= {r_qd[WIDTH-2:0], 1'b1};
            end else begin
                r_rd <= rd_sh;
                r_qd <= {r_qd[WIDTH-2:0], 1'b0};
            end
        end

        if (i_cmd.out_load) begin
            if (o_sts.den_zero) begin
                r_num_out <= r_n_raw;
                r_den_out <= r_d_raw;
                r_cd      <= '0;
                r_status  <= flt_pkg::STATUS_DEN_ZERO;
            end else begin
                r_num_out <= num_q_signed;
                r_den_out <= num_zero ? {{(WIDTH-1){1'b0}}, 1'b1} : den_q_signed;
                r_cd      <= r_g[WIDTH-1] ? '1 : r_g[WIDTH-2:0];
                r_status  <= flt_pkg::STATUS_OK;
            end
        end
    end

    assign o_num_out        = r_num_out;
    assign o_den_out        = r_den_out;
    assign o_common_divisor = r_cd;
    assign o_status         = r_status;

endmodule
`default_nettype wire

FILE: src/fraction_lowest_terms.sv
// Top level of the fraction reduction block: controller plus datapath.
//
// Input channel i_fraction carries num_in/den_in (signed, WIDTH bits); an
// item is taken when valid and ready are both high. Output channel o_result
// carries num_out, den_out, common_divisor and status under the same rule.
// One item is worked on at a time; ready on the input is high only when the
// controller is idle.
// Steps per item: a load, binary-gcd steps (one subtract or shift each,
// their number set by the magnitudes' bit lengths), forming the gcd, the
// two restoring dividers running side by side, and writing the result
// register. A zero denominator skips gcd and division.
// The result register parts the two sides: a new item may be accepted while
// the previous result still waits. If the receiver stalls, the finished
// item holds in the controller until the result register frees.
// Synchronous reset clears the controller and the output valid; no result
// is offered after reset until an item has completed.
`default_nettype none
module fraction_lowest_terms #(
    parameter int WIDTH = flt_pkg::WIDTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    flt_in_if.sink     i_fraction,
    flt_out_if.source  o_result
);
    flt_pkg::t_ctrl_cmd cmd;
    flt_pkg::t_ctrl_sts sts;

    flt_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_fraction.valid),
        .o_in_ready  (i_fraction.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    flt_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_num_in         (i_fraction.num_in),
        .i_den_in         (i_fraction.den_in),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_num_out        (o_result.num_out),
        .o_den_out        (o_result.den_out),
        .o_common_divisor (o_result.common_divisor),
        .o_status         (o_result.status)
    );

endmodule
`default_nettype wire
